// File: rtl/clutch_pkg.sv
// Package for the clutch torque and dynamics evaluator.
// Holds the breakpoint tables, per-segment derived constants and register codes.
// No dependencies; used by rtl/clutch_torque_and_dynamics_eval.sv.
package clutch_pkg;

  localparam int BREAKPOINT_COUNT = 5;
  localparam int SEG_COUNT        = BREAKPOINT_COUNT - 1;
  localparam int SEG_W            = $clog2(SEG_COUNT);

  // Breakpoints in Q4.28 radians: -5, -3, 0, 5.5 and 10 degrees
  localparam logic signed [31:0] ANGLE_PTS [BREAKPOINT_COUNT] = '{
    -32'sd23425413, -32'sd14055248, 32'sd0, 32'sd25767954, 32'sd46850825
  };

  // Whole torque values at the breakpoints
  localparam logic signed [15:0] TORQUE_PTS [BREAKPOINT_COUNT] = '{
    -16'sd1000, -16'sd30, 16'sd0, 16'sd50, 16'sd3500
  };

  // Lower breakpoint of each segment
  localparam logic signed [31:0] SEG_ANCHOR [SEG_COUNT] = '{
    ANGLE_PTS[0], ANGLE_PTS[1], ANGLE_PTS[2], ANGLE_PTS[3]
  };

  // Torque at the lower breakpoint, Q32.16
  localparam logic signed [47:0] SEG_BASE [SEG_COUNT] = '{
    48'(TORQUE_PTS[0]) <<< 16,
    48'(TORQUE_PTS[1]) <<< 16,
    48'(TORQUE_PTS[2]) <<< 16,
    48'(TORQUE_PTS[3]) <<< 16
  };

  // Torque rise across each segment (whole units, positive)
  localparam logic [11:0] SEG_RISE [SEG_COUNT] = '{
    12'(TORQUE_PTS[1] - TORQUE_PTS[0]),
    12'(TORQUE_PTS[2] - TORQUE_PTS[1]),
    12'(TORQUE_PTS[3] - TORQUE_PTS[2]),
    12'(TORQUE_PTS[4] - TORQUE_PTS[3])
  };

  // Angle span of each segment, Q4.28
  localparam logic [25:0] SEG_SPAN [SEG_COUNT] = '{
    26'(ANGLE_PTS[1] - ANGLE_PTS[0]),
    26'(ANGLE_PTS[2] - ANGLE_PTS[1]),
    26'(ANGLE_PTS[3] - ANGLE_PTS[2]),
    26'(ANGLE_PTS[4] - ANGLE_PTS[3])
  };

  // floor(rise * 2^16 * 2^31 / span): reciprocal for the interpolation estimate
  localparam logic [34:0] SEG_RECIP [SEG_COUNT] = '{
    35'((64'(SEG_RISE[0]) << 47) / 64'(SEG_SPAN[0])),
    35'((64'(SEG_RISE[1]) << 47) / 64'(SEG_SPAN[1])),
    35'((64'(SEG_RISE[2]) << 47) / 64'(SEG_SPAN[2])),
    35'((64'(SEG_RISE[3]) << 47) / 64'(SEG_SPAN[3]))
  };

  // Segment slope in Q32.16 torque per radian
  localparam logic signed [47:0] SEG_SLOPE [SEG_COUNT] = '{
    48'((64'(SEG_RISE[0]) << 44) / 64'(SEG_SPAN[0])),
    48'((64'(SEG_RISE[1]) << 44) / 64'(SEG_SPAN[1])),
    48'((64'(SEG_RISE[2]) << 44) / 64'(SEG_SPAN[2])),
    48'((64'(SEG_RISE[3]) << 44) / 64'(SEG_SPAN[3]))
  };

  localparam logic signed [47:0] Q48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] Q48_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [31:0] Q32_MAX = {1'b0, {31{1'b1}}};
  localparam logic signed [31:0] Q32_MIN = {1'b1, {31{1'b0}}};

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLIP_DAMPING    = 2'd0,
    CFG_VISCOUS_DAMPING = 2'd1,
    CFG_INVERSE_MASS    = 2'd2
  } cfg_reg_e;

  localparam logic [31:0] SLIP_DAMPING_RST    = 32'd655360;
  localparam logic [31:0] VISCOUS_DAMPING_RST = 32'd131072;
  localparam logic [31:0] INVERSE_MASS_RST    = 32'd6554;

endpackage

// File: rtl/clutch_torque_and_dynamics_eval.sv
// Throughput: one transaction per cycle while the output is not stalled;
// each of the 11 stages holds one item.
// A stalled output holds its stage; earlier stages keep filling empty slots, so the
// input stalls only when every stage holds an item and the output is stalled.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register defaults.
// The reciprocal and inverse-mass multipliers are cut into 32-bit partial products, one stage each.
module clutch_torque_and_dynamics_eval (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 angle_difference_i,
  input  logic signed [31:0]                 body_velocity_i,
  input  logic signed [31:0]                 drive_velocity_i,
  input  logic signed [31:0]                 external_torque_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [47:0]                 clutch_torque_o,
  output logic signed [47:0]                 curve_slope_o,
  output logic signed [31:0]                 angle_rate_o,
  output logic signed [31:0]                 slip_rate_o,
  output logic signed [47:0]                 acceleration_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [clutch_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);

  localparam int NSTAGE = 11;
  localparam int SW     = clutch_pkg::SEG_W;

  typedef struct packed {
    logic [SW-1:0]      seg;
    logic signed [31:0] body;
    logic signed [31:0] slip;
    logic signed [31:0] ext;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] angle;
  } s1_t;

  typedef struct packed {
    side_t              side;
    logic               xneg;
    logic [31:0]        mag;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s2_t;

  typedef struct packed {
    side_t              side;
    logic               xneg;
    logic [63:0]        plo;
    logic [34:0]        phi;
    logic [9:0]         nd;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s3_t;

  typedef struct packed {
    side_t              side;
    logic               xneg;
    logic [35:0]        est;
    logic [9:0]         nd;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s4_t;

  typedef struct packed {
    side_t              side;
    logic               xneg;
    logic [35:0]        est;
    logic [25:0]        em;
    logic [9:0]         nd;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s5_t;

  typedef struct packed {
    side_t              side;
    logic               xneg;
    logic [35:0]        quo;
    logic               rnz;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s6_t;

  typedef struct packed {
    side_t              side;
    logic signed [47:0] curve;
    logic signed [47:0] damp;
    logic signed [47:0] visc;
  } s7_t;

  typedef struct packed {
    side_t              side;
    logic signed [47:0] torque;
    logic signed [47:0] visc;
  } s8_t;

  typedef struct packed {
    side_t              side;
    logic signed [47:0] torque;
    logic signed [49:0] net;
  } s9_t;

  typedef struct packed {
    side_t              side;
    logic signed [47:0] torque;
    logic [63:0]        plo;
    logic signed [50:0] phi;
  } s10_t;

  // Configuration registers
  logic [31:0] slip_damping_q, viscous_damping_q, inverse_mass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_damping_q    <= clutch_pkg::SLIP_DAMPING_RST;
      viscous_damping_q <= clutch_pkg::VISCOUS_DAMPING_RST;
      inverse_mass_q    <= clutch_pkg::INVERSE_MASS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        clutch_pkg::CFG_SLIP_DAMPING:    slip_damping_q    <= cfg_data_i;
        clutch_pkg::CFG_VISCOUS_DAMPING: viscous_damping_q <= cfg_data_i;
        clutch_pkg::CFG_INVERSE_MASS:    inverse_mass_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Valid bits and stage advance
  logic [NSTAGE:1]   vld_q, vld_d;
  logic [NSTAGE+1:1] adv;

  always_comb begin
    adv[NSTAGE+1] = !out_stall_i;
    for (int k = NSTAGE; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d      = {vld_q[NSTAGE-1:1], in_valid_i};
  assign in_stall_o = !adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= NSTAGE; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  s1_t  s1_d,  s1_q;
  s2_t  s2_d,  s2_q;
  s3_t  s3_d,  s3_q;
  s4_t  s4_d,  s4_q;
  s5_t  s5_d,  s5_q;
  s6_t  s6_d,  s6_q;
  s7_t  s7_d,  s7_q;
  s8_t  s8_d,  s8_q;
  s9_t  s9_d,  s9_q;
  s10_t s10_d, s10_q;

  // Stage 1: segment search and slip rate
  logic [SW-1:0]      seg_sel;
  logic signed [32:0] slip_sum;

  always_comb begin
    seg_sel = SW'(clutch_pkg::SEG_COUNT - 1);
    for (int i = clutch_pkg::SEG_COUNT - 1; i >= 0; i--) begin
      if (angle_difference_i <= clutch_pkg::ANGLE_PTS[i+1]) seg_sel = SW'(i);
    end
    slip_sum = {body_velocity_i[31], body_velocity_i}
             + {drive_velocity_i[31], drive_velocity_i};
    s1_d.side.seg  = seg_sel;
    s1_d.side.body = body_velocity_i;
    s1_d.side.ext  = external_torque_i;
    if (slip_sum[32] != slip_sum[31]) begin
      s1_d.side.slip = slip_sum[32] ? clutch_pkg::Q32_MIN : clutch_pkg::Q32_MAX;
    end else begin
      s1_d.side.slip = slip_sum[31:0];
    end
    s1_d.angle = angle_difference_i;
  end

  // Stage 2: offset into the segment, damping products
  logic signed [32:0] x_diff;
  logic [32:0]        x_mag;
  logic signed [32:0] slip_damp_s, visc_damp_s, inv_mass_s;
  logic signed [64:0] damp_prod, visc_prod;

  assign slip_damp_s = $signed({1'b0, slip_damping_q});
  assign visc_damp_s = $signed({1'b0, viscous_damping_q});
  assign inv_mass_s  = $signed({1'b0, inverse_mass_q});

  always_comb begin
    x_diff = $signed({s1_q.angle[31], s1_q.angle})
           - $signed({clutch_pkg::SEG_ANCHOR[s1_q.side.seg][31],
                      clutch_pkg::SEG_ANCHOR[s1_q.side.seg]});
    x_mag  = x_diff[32] ? 33'(-x_diff) : 33'(x_diff);
    damp_prod = $signed(s1_q.side.slip) * slip_damp_s;
    visc_prod = $signed(s1_q.side.body) * visc_damp_s;
    s2_d.side = s1_q.side;
    s2_d.xneg = x_diff[32];
    s2_d.mag  = x_mag[31:0];
    // floor of the Q16.16 product is the arithmetic shift
    s2_d.damp = damp_prod[63:16];
    s2_d.visc = visc_prod[63:16];
  end

  // Stage 3: quotient estimate partial products, low remainder bits
  logic [34:0] recip_sel;
  logic [19:0] nd_prod;

  always_comb begin
    recip_sel = clutch_pkg::SEG_RECIP[s2_q.side.seg];
    nd_prod   = s2_q.mag[9:0] * clutch_pkg::SEG_RISE[s2_q.side.seg][9:0];
    s3_d.side = s2_q.side;
    s3_d.xneg = s2_q.xneg;
    s3_d.plo  = s2_q.mag * recip_sel[31:0];
    s3_d.phi  = s2_q.mag * recip_sel[34:32];
    s3_d.nd   = nd_prod[9:0];
    s3_d.damp = s2_q.damp;
    s3_d.visc = s2_q.visc;
  end

  // Stage 4: combine partial products; the estimate is floor or floor - 1
  logic [66:0] est_sum;

  always_comb begin
    est_sum   = {3'b000, s3_q.plo} + {s3_q.phi, 32'd0};
    s4_d.side = s3_q.side;
    s4_d.xneg = s3_q.xneg;
    s4_d.est  = est_sum[66:31];
    s4_d.nd   = s3_q.nd;
    s4_d.damp = s3_q.damp;
    s4_d.visc = s3_q.visc;
  end

  // Stage 5: estimate times span, modulo 2^26 (enough for the remainder)
  logic [25:0] span_s5;
  logic [51:0] em_prod;

  always_comb begin
    span_s5   = clutch_pkg::SEG_SPAN[s4_q.side.seg];
    em_prod   = s4_q.est[25:0] * span_s5;
    s5_d.side = s4_q.side;
    s5_d.xneg = s4_q.xneg;
    s5_d.est  = s4_q.est;
    s5_d.em   = em_prod[25:0];
    s5_d.nd   = s4_q.nd;
    s5_d.damp = s4_q.damp;
    s5_d.visc = s4_q.visc;
  end

  // Stage 6: remainder check, correct the quotient
  logic [25:0] span_s6, rem_raw;
  logic        rem_ge;

  always_comb begin
    span_s6   = clutch_pkg::SEG_SPAN[s5_q.side.seg];
    rem_raw   = {s5_q.nd, 16'd0} - s5_q.em;
    rem_ge    = rem_raw >= span_s6;
    s6_d.side = s5_q.side;
    s6_d.xneg = s5_q.xneg;
    s6_d.quo  = s5_q.est + 36'(rem_ge);
    s6_d.rnz  = rem_ge ? (rem_raw != span_s6) : (rem_raw != '0);
    s6_d.damp = s5_q.damp;
    s6_d.visc = s5_q.visc;
  end

  // Stage 7: signed floor of the interpolation, add segment base
  logic [36:0]        quo_adj;
  logic signed [36:0] quo_signed;

  always_comb begin
    // below the anchor, floor of a negative value rounds away from zero
    quo_adj    = {1'b0, s6_q.quo} + 37'(s6_q.rnz);
    quo_signed = s6_q.xneg ? -$signed(quo_adj) : $signed({1'b0, s6_q.quo});
    s7_d.side  = s6_q.side;
    s7_d.curve = clutch_pkg::SEG_BASE[s6_q.side.seg]
               + $signed({{11{quo_signed[36]}}, quo_signed});
    s7_d.damp  = s6_q.damp;
    s7_d.visc  = s6_q.visc;
  end

  // Stage 8: clutch torque with saturation
  logic signed [48:0] torque_sum;

  always_comb begin
    torque_sum = $signed({s7_q.curve[47], s7_q.curve}) + $signed({s7_q.damp[47], s7_q.damp});
    s8_d.side  = s7_q.side;
    s8_d.visc  = s7_q.visc;
    if (torque_sum[48] != torque_sum[47]) begin
      s8_d.torque = torque_sum[48] ? clutch_pkg::Q48_MIN : clutch_pkg::Q48_MAX;
    end else begin
      s8_d.torque = torque_sum[47:0];
    end
  end

  // Stage 9: net torque, exact
  always_comb begin
    s9_d.side   = s8_q.side;
    s9_d.torque = s8_q.torque;
    s9_d.net    = $signed({{18{s8_q.side.ext[31]}}, s8_q.side.ext})
                - $signed({{2{s8_q.torque[47]}}, s8_q.torque})
                - $signed({{2{s8_q.visc[47]}}, s8_q.visc});
  end

  // Stage 10: net torque times inverse mass, split at bit 32 of the net
  always_comb begin
    s10_d.side   = s9_q.side;
    s10_d.torque = s9_q.torque;
    s10_d.plo    = s9_q.net[31:0] * inverse_mass_q;
    s10_d.phi    = $signed(s9_q.net[49:32]) * inv_mass_s;
  end

  // Stage 11: sum partial products, floor shift and saturate into the output register
  logic signed [82:0] accel_prod;
  logic               accel_ovf;
  logic signed [47:0] accel_d;

  always_comb begin
    accel_prod = $signed({s10_q.phi, 32'd0}) + $signed({19'd0, s10_q.plo});
    accel_ovf  = accel_prod[82:63] != {20{accel_prod[63]}};
    if (accel_ovf) begin
      accel_d = accel_prod[82] ? clutch_pkg::Q48_MIN : clutch_pkg::Q48_MAX;
    end else begin
      accel_d = accel_prod[63:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1])  s1_q  <= s1_d;
    if (adv[2])  s2_q  <= s2_d;
    if (adv[3])  s3_q  <= s3_d;
    if (adv[4])  s4_q  <= s4_d;
    if (adv[5])  s5_q  <= s5_d;
    if (adv[6])  s6_q  <= s6_d;
    if (adv[7])  s7_q  <= s7_d;
    if (adv[8])  s8_q  <= s8_d;
    if (adv[9])  s9_q  <= s9_d;
    if (adv[10]) s10_q <= s10_d;
  end

  logic signed [47:0] clutch_torque_q, curve_slope_q, acceleration_q;
  logic signed [31:0] angle_rate_q, slip_rate_q;

  always_ff @(posedge clk_i) begin
    if (adv[NSTAGE]) begin
      clutch_torque_q <= s10_q.torque;
      curve_slope_q   <= clutch_pkg::SEG_SLOPE[s10_q.side.seg];
      angle_rate_q    <= s10_q.side.body;
      slip_rate_q     <= s10_q.side.slip;
      acceleration_q  <= accel_d;
    end
  end

  assign out_valid_o     = vld_q[NSTAGE];
  assign clutch_torque_o = clutch_torque_q;
  assign curve_slope_o   = curve_slope_q;
  assign angle_rate_o    = angle_rate_q;
  assign slip_rate_o     = slip_rate_q;
  assign acceleration_o  = acceleration_q;

`ifndef SYNTHESIS
  // Input stalls only with a full pipeline behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && (&vld_q)))
    else $error("input stalled with room in the pipeline");

  // Reciprocal estimate is off by at most one: raw remainder below twice the span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> ({1'b0, rem_raw} < {span_s6, 1'b0}))
    else $error("interpolation remainder out of range");

  // A result leaves the output only through a completed transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(!out_stall_i))
    else $error("result dropped while stalled");
`endif

endmodule
